>>> rtl/core/kvfd_pkg.sv
package kvfd_pkg;

    typedef enum logic [2:0] {
        PH_LEN,
        PH_COUNT,
        PH_KLEN,
        PH_KEY,
        PH_VLEN,
        PH_VAL,
        PH_TRAIL,
        PH_SKIP
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_KEY,
        KIND_VALUE,
        KIND_SKIP
    } t_byte_kind;

    typedef enum logic [1:0] {
        ST_OK,
        ST_HDR_SHORT,
        ST_KEY_OVERRUN,
        ST_VAL_OVERRUN
    } t_status;

    localparam logic [2:0] LEN_HDR_BYTES   = 3'd4;
    localparam logic [2:0] SHORT_HDR_BYTES = 3'd2;

    typedef struct packed {
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        t_byte_kind  byte_kind;
        logic [7:0]  data_byte;
        logic [15:0] field_number;
        logic        segment_last;
        logic        field_done;
        logic        frame_done;
        t_status     frame_status;
    } t_out_item;

endpackage

>>> rtl/core/kvfd_stream_if.sv
interface kvfd_stream_if #(
    parameter type t_payload = logic [7:0]
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/kvfd_parser.sv
module kvfd_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic [7:0]         i_data,
    output kvfd_pkg::t_out_item o_item
);
    import kvfd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_header_byte_count, n_header_byte_count;
    logic [31:0] r_header_shift, n_header_shift;
    logic [31:0] r_frame_bytes_left, n_frame_bytes_left;
    logic [15:0] r_pairs_left, n_pairs_left;
    logic [15:0] r_pair_index, n_pair_index;
    logic [31:0] r_segment_bytes_left, n_segment_bytes_left;
    t_status     r_error_code, n_error_code;

    logic [31:0] fbl_dec;
    logic [31:0] seg_dec;
    logic [15:0] pairs_dec;
    logic [31:0] shift_new;
    logic [2:0]  cnt_inc;
    logic        hdr_need4;
    logic        hdr_done;
    t_out_item   item;

    always_comb begin
        fbl_dec   = r_frame_bytes_left - 32'd1;
        seg_dec   = r_segment_bytes_left - 32'd1;
        pairs_dec = r_pairs_left - 16'd1;
        shift_new = {r_header_shift[23:0], i_data};
        cnt_inc   = {1'b0, r_header_byte_count} + 3'd1;
        hdr_need4 = (r_phase == PH_LEN) || (r_phase == PH_VLEN);
        hdr_done  = hdr_need4 ? (cnt_inc >= LEN_HDR_BYTES) : (cnt_inc >= SHORT_HDR_BYTES);

        n_phase              = r_phase;
        n_header_byte_count  = r_header_byte_count;
        n_header_shift       = r_header_shift;
        n_frame_bytes_left   = r_frame_bytes_left;
        n_pairs_left         = r_pairs_left;
        n_pair_index         = r_pair_index;
        n_segment_bytes_left = r_segment_bytes_left;
        n_error_code         = r_error_code;

        item.byte_kind    = KIND_SKIP;
        item.data_byte    = i_data;
        item.field_number = r_pair_index;
        item.segment_last = 1'b0;
        item.field_done   = 1'b0;
        item.frame_done   = 1'b0;
        item.frame_status = ST_OK;

        // header shift and byte count, shared by all header phases
        if (r_phase == PH_LEN || r_phase == PH_COUNT || r_phase == PH_KLEN
                || r_phase == PH_VLEN) begin
            if (hdr_done) begin
                n_header_byte_count = 2'd0;
                n_header_shift      = '0;
            end else begin
                n_header_byte_count = cnt_inc[1:0];
                n_header_shift      = shift_new;
            end
        end

        if (r_phase != PH_LEN) begin
            n_frame_bytes_left = fbl_dec;
        end

        unique case (r_phase)
            PH_LEN: begin
                item.byte_kind = KIND_HEADER;
                if (hdr_done) begin
                    n_frame_bytes_left = shift_new;
                    if (shift_new == '0) begin
                        item.frame_done = 1'b1;
                    end else begin
                        n_phase = PH_COUNT;
                    end
                end
            end
            PH_COUNT: begin
                item.byte_kind = KIND_HEADER;
                if (hdr_done) begin
                    n_pairs_left = shift_new[15:0];
                    n_phase      = (shift_new[15:0] != '0) ? PH_KLEN : PH_TRAIL;
                end
            end
            PH_KLEN: begin
                item.byte_kind = KIND_HEADER;
                if (hdr_done) begin
                    n_segment_bytes_left = {16'd0, shift_new[15:0]};
                    if ({16'd0, shift_new[15:0]} > fbl_dec) begin
                        n_error_code = ST_KEY_OVERRUN;
                        n_phase      = PH_SKIP;
                    end else begin
                        n_phase = (shift_new[15:0] != '0) ? PH_KEY : PH_VLEN;
                    end
                end
            end
            PH_KEY: begin
                item.byte_kind       = KIND_KEY;
                n_segment_bytes_left = seg_dec;
                if (seg_dec == '0) begin
                    item.segment_last = 1'b1;
                    n_phase           = PH_VLEN;
                end
            end
            PH_VLEN: begin
                item.byte_kind = KIND_HEADER;
                if (hdr_done) begin
                    n_segment_bytes_left = shift_new;
                    if (shift_new > fbl_dec) begin
                        n_error_code = ST_VAL_OVERRUN;
                        n_phase      = PH_SKIP;
                    end else if (shift_new == '0) begin
                        item.field_done = 1'b1;
                        n_pair_index    = r_pair_index + 16'd1;
                        n_pairs_left    = pairs_dec;
                        n_phase         = (pairs_dec != '0) ? PH_KLEN : PH_TRAIL;
                    end else begin
                        n_phase = PH_VAL;
                    end
                end
            end
            PH_VAL: begin
                item.byte_kind       = KIND_VALUE;
                n_segment_bytes_left = seg_dec;
                if (seg_dec == '0) begin
                    item.segment_last = 1'b1;
                    item.field_done   = 1'b1;
                    n_pair_index      = r_pair_index + 16'd1;
                    n_pairs_left      = pairs_dec;
                    n_phase           = (pairs_dec != '0) ? PH_KLEN : PH_TRAIL;
                end
            end
            PH_TRAIL, PH_SKIP: begin
                item.byte_kind = KIND_SKIP;
            end
        endcase

        // frame end: report status and return to length search
        if (r_phase != PH_LEN && fbl_dec == '0) begin
            item.frame_done = 1'b1;
            if (n_error_code != ST_OK) begin
                item.frame_status = n_error_code;
            end else if (n_phase != PH_TRAIL && n_phase != PH_SKIP) begin
                item.frame_status = ST_HDR_SHORT;
            end else begin
                item.frame_status = ST_OK;
            end
        end

        if (item.frame_done) begin
            n_phase              = PH_LEN;
            n_header_byte_count  = 2'd0;
            n_header_shift       = '0;
            n_frame_bytes_left   = '0;
            n_pairs_left         = '0;
            n_pair_index         = '0;
            n_segment_bytes_left = '0;
            n_error_code         = ST_OK;
        end
    end

    assign o_item = item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase              <= PH_LEN;
            r_header_byte_count  <= 2'd0;
            r_header_shift       <= '0;
            r_frame_bytes_left   <= '0;
            r_pairs_left         <= '0;
            r_pair_index         <= '0;
            r_segment_bytes_left <= '0;
            r_error_code         <= ST_OK;
        end else if (i_advance) begin
            r_phase              <= n_phase;
            r_header_byte_count  <= n_header_byte_count;
            r_header_shift       <= n_header_shift;
            r_frame_bytes_left   <= n_frame_bytes_left;
            r_pairs_left         <= n_pairs_left;
            r_pair_index         <= n_pair_index;
            r_segment_bytes_left <= n_segment_bytes_left;
            r_error_code         <= n_error_code;
        end
    end

    a_skip_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SKIP |-> r_error_code != ST_OK)
        else $error("skip phase without latched error");

    a_len_phase_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LEN |-> r_frame_bytes_left == '0 && r_pair_index == '0)
        else $error("frame state not cleared in length phase");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && item.frame_done |=> r_phase == PH_LEN && r_error_code == ST_OK)
        else $error("frame end did not return to length phase");

    a_status_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item.frame_status != ST_OK |-> item.frame_done)
        else $error("status reported away from frame end");

    a_field_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item.field_done |-> item.byte_kind == KIND_VALUE || item.byte_kind == KIND_HEADER)
        else $error("field done on key or skipped byte");

endmodule

>>> rtl/core/kvfd_out_stage.sv
module kvfd_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  kvfd_pkg::t_out_item i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output kvfd_pkg::t_out_item o_item
);
    import kvfd_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload register, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

>>> rtl/core/kv_frame_deframer_top.sv
// kv_frame_deframer_top: streaming parser for length-prefixed key/value frames
//
// i_byte_if (sink) carries one stream byte per transaction, frames back to
// back: 4-byte big-endian frame length, 16-bit pair count, then per pair a
// 16-bit key length, key bytes, 32-bit value length and value bytes.
// o_res_if (source) carries one tagged result per input byte, in order:
// byte kind, the byte itself, field number, segment/field/frame end marks
// and the frame status on the last byte of each frame.
//
// timing: the result is registered, valid in the cycle after the input transaction.
// throughput: one byte per cycle while not stalled; parsing is done by one level
// of counter updates and 32-bit compares ahead of the result register.
// reset: parser returns to awaiting a frame length, result register empty.
// stall: while a result waits and o_res_if.ready is low, i_byte_if.ready is
// low and the parser state holds; nothing is dropped.
module kv_frame_deframer_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kvfd_stream_if.sink   i_byte_if,
    kvfd_stream_if.source o_res_if
);
    import kvfd_pkg::*;

    logic      accept;
    logic      stage_ready;
    t_in_item  in_item;
    t_out_item parsed;

    assign in_item          = i_byte_if.payload;
    assign i_byte_if.ready  = stage_ready;
    assign accept           = i_byte_if.valid && stage_ready;

    kvfd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept),
        .i_data    (in_item.in_byte),
        .o_item    (parsed)
    );

    kvfd_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_byte_if.valid),
        .o_ready (stage_ready),
        .i_item  (parsed),
        .o_valid (o_res_if.valid),
        .i_ready (o_res_if.ready),
        .o_item  (o_res_if.payload)
    );

endmodule
